/* hw/rtl/sptw_pkg.sv */
`timescale 1ns / 1ps

package sptw_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_L1   = 2'd1,
        PH_L2   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_L1   = 2'd1,
        FAULT_L2   = 2'd2
    } t_fault;

    localparam logic REQ_XLATE = 1'b0;
    localparam logic REQ_PTE   = 1'b1;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned PAGE_BITS = 12;
    localparam int unsigned VPN_W     = 10;

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   addr;
        t_fault              fault;
    } t_result;

    // Physical page base taken from entry bits 29..10.
    function automatic logic [ADDR_W-1:0] entry_page(input logic [ADDR_W-1:0] pte);
        entry_page = {pte[29:10], {PAGE_BITS{1'b0}}};
    endfunction

endpackage

/* hw/rtl/sv32_page_table_walker_core.sv */
`timescale 1ns / 1ps
// Each result is registered in the output register, or in the skid stage if that is held.
// Throughput: one request per cycle while the skid stage is empty; the output register
// plus a one-entry skid stage keep input ready high while a single result waits downstream.
// Reset (synchronous, active low): satp is cleared, the walker returns to idle,
// and both output stages are emptied.
module sv32_page_table_walker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_pte_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_out_addr,
    output logic [1:0]  o_fault_code
);
    import sptw_pkg::*;

    logic [31:0] r_satp;
    t_phase      r_phase;
    logic [31:0] r_held_vaddr;
    t_phase      n_phase;
    logic [31:0] n_held_vaddr;
    logic        accept;
    logic        push;
    t_result     step_result;
    t_result     out_result;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_satp       <= '0;
            r_phase      <= PH_IDLE;
            r_held_vaddr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_satp <= i_cfg_data;
            end
            r_phase      <= n_phase;
            r_held_vaddr <= n_held_vaddr;
        end
    end

    sptw_step u_step (
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_virt_addr  (i_virt_addr),
        .i_pte_word   (i_pte_word),
        .i_satp       (r_satp),
        .i_phase      (r_phase),
        .i_held_vaddr (r_held_vaddr),
        .o_next_phase (n_phase),
        .o_next_held  (n_held_vaddr),
        .o_push       (push),
        .o_result     (step_result)
    );

    sptw_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (step_result),
        .o_space  (o_in_ready),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_result_kind = out_result.kind;
    assign o_out_addr    = out_result.addr;
    assign o_fault_code  = out_result.fault;

    a_idle_ignores_pte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req_type == REQ_PTE) && (r_phase == PH_IDLE))
            |=> (r_phase == PH_IDLE))
        else $error("entry response while idle started a walk");

    a_busy_holds_vaddr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |=> ($stable(r_held_vaddr) || ($past(r_phase) == PH_IDLE)))
        else $error("held virtual address changed during a walk");

    a_walk_start_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_IDLE) && (n_phase == PH_L1)) |-> push)
        else $error("walk started without a level-1 read request");

endmodule

/* hw/rtl/sptw_step.sv */
`timescale 1ns / 1ps

module sptw_step (
    input  logic                    i_accept,
    input  logic                    i_req_type,
    input  logic [31:0]             i_virt_addr,
    input  logic [31:0]             i_pte_word,
    input  logic [31:0]             i_satp,
    input  sptw_pkg::t_phase        i_phase,
    input  logic [31:0]             i_held_vaddr,
    output sptw_pkg::t_phase        o_next_phase,
    output logic [31:0]             o_next_held,
    output logic                    o_push,
    output sptw_pkg::t_result       o_result
);
    import sptw_pkg::*;

    logic              busy;
    logic [ADDR_W-1:0] l1_addr;
    logic [ADDR_W-1:0] l2_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic              l2_bad;

    // Phase value three is unreachable; it behaves like idle.
    assign busy = (i_phase == PH_L1) || (i_phase == PH_L2);

    assign l1_addr   = {i_satp[19:0], {PAGE_BITS{1'b0}}}
                     + {20'd0, i_virt_addr[31:22], 2'b00};
    assign l2_addr   = entry_page(i_pte_word) + {20'd0, i_held_vaddr[21:12], 2'b00};
    assign phys_addr = entry_page(i_pte_word) + {20'd0, i_held_vaddr[11:0]};
    assign l2_bad    = !i_pte_word[0] || (i_pte_word[3:1] == 3'd0);

    // Next state.
    always_comb begin
        o_next_phase = i_phase;
        o_next_held  = i_held_vaddr;
        if (i_accept) begin
            if (i_req_type == REQ_XLATE) begin
                if (!busy && (i_satp != 32'd0)) begin
                    o_next_phase = PH_L1;
                    o_next_held  = i_virt_addr;
                end
            end else begin
                unique case (i_phase)
                    PH_L1:   o_next_phase = i_pte_word[0] ? PH_L2 : PH_IDLE;
                    PH_L2:   o_next_phase = PH_IDLE;
                    default: o_next_phase = i_phase;
                endcase
            end
        end
    end

    // Result.
    always_comb begin
        o_push         = 1'b0;
        o_result.kind  = KIND_READ;
        o_result.addr  = '0;
        o_result.fault = FAULT_NONE;
        if (i_accept) begin
            if (i_req_type == REQ_XLATE) begin
                if (!busy) begin
                    o_push = 1'b1;
                    if (i_satp == 32'd0) begin
                        o_result.kind = KIND_DONE;
                        o_result.addr = i_virt_addr;
                    end else begin
                        o_result.kind = KIND_READ;
                        o_result.addr = l1_addr;
                    end
                end
            end else begin
                unique case (i_phase)
                    PH_L1: begin
                        o_push = 1'b1;
                        if (i_pte_word[0]) begin
                            o_result.kind = KIND_READ;
                            o_result.addr = l2_addr;
                        end else begin
                            o_result.kind  = KIND_FAULT;
                            o_result.fault = FAULT_L1;
                        end
                    end
                    PH_L2: begin
                        o_push = 1'b1;
                        if (l2_bad) begin
                            o_result.kind  = KIND_FAULT;
                            o_result.fault = FAULT_L2;
                        end else begin
                            o_result.kind = KIND_DONE;
                            o_result.addr = phys_addr;
                        end
                    end
                    default: o_push = 1'b0;
                endcase
            end
        end
    end

endmodule

/* hw/rtl/sptw_out_buf.sv */
`timescale 1ns / 1ps

module sptw_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sptw_pkg::t_result   i_result,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output sptw_pkg::t_result   o_result
);
    import sptw_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop      = r_out_valid && i_ready;
    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_skid_valid))
        else $error("request pushed into full output buffer");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output register");

endmodule

/* tb/sptw_checker.sv */
`timescale 1ns / 1ps

module sptw_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_pte_word,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_result_kind,
    input  logic [31:0] i_out_addr,
    input  logic [1:0]  i_fault_code,
    output int          o_fail_count,
    output int          o_pending
);
    import sptw_pkg::*;

    logic [31:0] satp_copy;
    t_phase      phase;
    logic [31:0] walk_va;
    t_result     due_results[$];
    int          fail_tally = 0;

    // Advances the walker copy by one accepted request and queues the outcome, if any.
    task automatic walk_step(input logic rtype, input logic [31:0] va, input logic [31:0] pte);
        t_result r;
        logic    hit;
        logic    busy;
        hit     = 1'b0;
        busy    = (phase == PH_L1) || (phase == PH_L2);
        r.kind  = KIND_READ;
        r.addr  = '0;
        r.fault = FAULT_NONE;
        if (rtype == REQ_XLATE) begin
            if (!busy) begin
                hit = 1'b1;
                if (satp_copy == 32'd0) begin
                    r.kind = KIND_DONE;
                    r.addr = va;
                end else begin
                    walk_va = va;
                    phase   = PH_L1;
                    // Root page number shifted by 12 wraps at 32 bits.
                    r.addr  = {satp_copy[19:0], 12'h000} + {20'h0, va[31:22], 2'b00};
                end
            end
        end else if (phase == PH_L1) begin
            hit = 1'b1;
            if (!pte[0]) begin
                phase   = PH_IDLE;
                r.kind  = KIND_FAULT;
                r.fault = FAULT_L1;
            end else begin
                phase  = PH_L2;
                r.addr = {pte[29:10], 12'h000} + {20'h0, walk_va[21:12], 2'b00};
            end
        end else if (phase == PH_L2) begin
            hit   = 1'b1;
            phase = PH_IDLE;
            if (!pte[0] || pte[3:1] == 3'b000) begin
                r.kind  = KIND_FAULT;
                r.fault = FAULT_L2;
            end else begin
                r.kind = KIND_DONE;
                r.addr = {pte[29:10], walk_va[11:0]};
            end
        end
        if (hit) due_results.insert(due_results.size(), r);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            satp_copy = '0;
            phase     = PH_IDLE;
            walk_va   = '0;
            due_results.delete();
        end else begin
            if (i_cfg_we) satp_copy = i_cfg_data;
            // The result side is checked before the new request is queued, so a stray
            // result can never pair up with an expectation created at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: kind %0d addr %h fault %0d",
                           i_result_kind, i_out_addr, i_fault_code);
                    fail_tally++;
                end else begin
                    want = due_results.pop_front();
                    if (i_result_kind !== want.kind) begin
                        $error("result_kind: expected %0d, actual %0d", want.kind, i_result_kind);
                        fail_tally++;
                    end
                    if (i_out_addr !== want.addr) begin
                        $error("out_addr: expected %h, actual %h", want.addr, i_out_addr);
                        fail_tally++;
                    end
                    if (i_fault_code !== want.fault) begin
                        $error("fault_code: expected %0d, actual %0d", want.fault, i_fault_code);
                        fail_tally++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) walk_step(i_req_type, i_virt_addr, i_pte_word);
        end
        o_pending    <= due_results.size();
        o_fail_count <= fail_tally;
    end

endmodule

/* tb/tb_sv32_page_table_walker_core.sv */
`timescale 1ns / 1ps

module tb_sv32_page_table_walker_core;
    import sptw_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_req_type;
    logic [31:0] i_virt_addr;
    logic [31:0] i_pte_word;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_result_kind;
    logic [31:0] o_out_addr;
    logic [1:0]  o_fault_code;

    int          fail_n;
    int          pend_n;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        rx_hold = 1'b0;
    logic [31:0] cur_satp = '0;
    int          sent_n = 0;
    int          cfg_n = 0;

    always #4 i_clk = ~i_clk;

    sv32_page_table_walker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_virt_addr   (i_virt_addr),
        .i_pte_word    (i_pte_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_out_addr    (o_out_addr),
        .o_fault_code  (o_fault_code)
    );

    sptw_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_virt_addr   (i_virt_addr),
        .i_pte_word    (i_pte_word),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_result_kind (o_result_kind),
        .i_out_addr    (o_out_addr),
        .i_fault_code  (o_fault_code),
        .o_fail_count  (fail_n),
        .o_pending     (pend_n)
    );

    // Receiver side: random back-pressure, or one long hold-off when the stimulus asks.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                rx_hold = 1'b0;
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Offers one request, with random gaps before it, and returns at the edge it is taken.
    task automatic push(input logic rtype, input logic [31:0] va, input logic [31:0] pte);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= rtype;
        i_virt_addr <= va;
        i_pte_word  <= pte;
        sent_n++;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stops offering and waits until every predicted result has come out.
    // It waits for the next edge first so the pending count includes the last request taken.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pend_n != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_satp(input logic [31:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_satp = value;
        cfg_n++;
    endtask

    // Mostly complete walks with random content; some noise and abandoned walks.
    task automatic run_walks(input int n);
        int          done_n;
        int          pick;
        int          sel;
        logic [31:0] l1;
        logic [31:0] l2;
        done_n = 0;
        while (done_n < n) begin
            pick = $urandom_range(99);
            if (pick == 0) begin
                settle();
            end else if (pick < 9) begin
                push(1'($urandom_range(1)), $urandom, $urandom);
            end else if (cur_satp == 32'd0) begin
                push(REQ_XLATE, $urandom, $urandom);
                done_n++;
            end else begin
                push(REQ_XLATE, $urandom, $urandom);
                done_n++;
                // A few walks are left hanging so the next request meets a busy walker.
                if (pick >= 14) begin
                    l1    = $urandom;
                    l1[0] = ($urandom_range(99) < 85);
                    push(REQ_PTE, $urandom, l1);
                    done_n++;
                    if (l1[0]) begin
                        l2  = $urandom;
                        sel = $urandom_range(99);
                        if (sel < 10) begin
                            l2[0] = 1'b0;
                        end else begin
                            l2[0] = 1'b1;
                            if (sel < 22) l2[3:1] = 3'b000;
                            else if (l2[3:1] == 3'b000) l2[1] = 1'b1;
                        end
                        push(REQ_PTE, $urandom, l2);
                        done_n++;
                    end
                end
            end
        end
    endtask

    initial begin
        logic [31:0] v;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_req_type  <= REQ_XLATE;
        i_virt_addr <= '0;
        i_pte_word  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Translation off: addresses pass through, a stray entry response is dropped.
        write_satp(32'h0000_0000);
        push(REQ_XLATE, 32'h0000_0000, 32'h0);
        push(REQ_XLATE, 32'hFFFF_FFFF, 32'h0);
        push(REQ_PTE,   32'h0000_0000, 32'hFFFF_FFFF);

        write_satp(32'hFFFF_FFFF);
        push(REQ_XLATE, 32'hFFFF_FFFF, 32'h0);
        push(REQ_XLATE, 32'h0000_0000, 32'h0);          // dropped, walk is busy
        push(REQ_PTE,   32'h0,         32'hFFFF_FFFE);  // level-1 entry not valid
        push(REQ_XLATE, 32'h0000_0000, 32'h0);
        push(REQ_PTE,   32'h0,         32'h0000_0001);
        push(REQ_XLATE, 32'hFFFF_FFFF, 32'h0);          // dropped during level 2
        push(REQ_PTE,   32'h0,         32'hFFFF_FFF1);  // valid but no R, W or X
        push(REQ_XLATE, 32'h1234_5678, 32'h0);
        push(REQ_PTE,   32'h0,         32'hFFFF_FFFF);
        push(REQ_PTE,   32'h0,         32'hFFFF_FFFF);  // entry bits 31:30 are ignored
        push(REQ_XLATE, 32'hFFFF_FFFF, 32'h0);
        push(REQ_PTE,   32'h0,         32'h0000_0001);
        push(REQ_PTE,   32'h0,         32'h0000_000E);  // level-2 entry not valid

        write_satp(32'h0000_0001);
        push(REQ_XLATE, 32'h0000_0FFF, 32'h0);
        push(REQ_PTE,   32'h0,         32'h0000_0401);
        push(REQ_PTE,   32'h0,         32'h0000_0003);

        // Nonzero satp with a zero root page number still enables translation.
        write_satp(32'hFFC0_0000);
        push(REQ_XLATE, 32'hABCD_E123, 32'h0);
        push(REQ_PTE,   32'h0,         32'h3FFF_FC01);
        push(REQ_PTE,   32'h0,         32'hC000_0009);
        push(REQ_PTE,   32'h0,         32'h0);

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 72 : 0;
            rx_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 38 : 0;
            if (mode == 0) begin
                // Hold the output off long enough that the block must stall its input.
                write_satp(32'h0);
                rx_hold = 1'b1;
                repeat (40) push(REQ_XLATE, $urandom, $urandom);
            end
            for (int k = 0; k < 4; k++) begin
                case ((mode * 4 + k) % 6)
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'hFFC0_0000;
                    4: v = $urandom;
                    default: v = $urandom | 32'h1;
                endcase
                write_satp(v);
                run_walks(125);
            end
        end

        settle();
        repeat (16) @(posedge i_clk);
        $display("Covered %0d requests over %0d satp settings, three pacing modes", sent_n, cfg_n);
        $display("and one long output stall; %0d check failures seen.", fail_n);
        if (fail_n == 0 && pend_n == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
